[rtl/core/cbf_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the comment blanking filter.
package cbf_pkg;

    localparam int LINE_COUNT_BITS_DEF = 20;
    localparam int QUEUE_DEPTH_DEF     = 4;
    localparam int OUT_LINE_W          = 20;

    localparam logic [OUT_LINE_W-1:0] FIELD_MAX = {OUT_LINE_W{1'b1}};

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // Scanner modes
    typedef enum logic [4:0] {
        MODE_NORMAL     = 5'b00001,
        MODE_SLASH      = 5'b00010,
        MODE_LINE       = 5'b00100,
        MODE_BLOCK      = 5'b01000,
        MODE_BLOCK_STAR = 5'b10000
    } t_mode;

    // One queue entry: the one or two words that a single input byte produces.
    // The end-of-text fields belong to the last word of the entry.
    typedef struct packed {
        logic                  two;
        logic [7:0]            first_byte;
        logic [7:0]            second_byte;
        logic                  fin;
        logic                  err;
        logic [OUT_LINE_W-1:0] open_line;
        logic [OUT_LINE_W-1:0] total_lines;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/core/cbf_front.sv]
`timescale 1ns / 1ps
// Front end: accepts text bytes, tracks comment mode and line counts, builds queue entries.
module cbf_front #(
    parameter int LINE_COUNT_BITS = cbf_pkg::LINE_COUNT_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_text_byte,
    input  logic               i_is_final,
    input  cbf_pkg::t_q_status i_q_status,
    output logic               o_push,
    output cbf_pkg::t_cmd      o_cmd
);
    import cbf_pkg::*;

    localparam int WideW = (LINE_COUNT_BITS > OUT_LINE_W) ? LINE_COUNT_BITS : OUT_LINE_W;

    t_mode                      r_mode, n_mode;
    logic [LINE_COUNT_BITS-1:0] r_line, n_line;
    logic [LINE_COUNT_BITS-1:0] r_open, n_open;
    logic                       accept;
    logic                       emit;
    logic                       in_block;
    logic                       is_nl, is_slash, is_star;

    function automatic logic [OUT_LINE_W-1:0] clamp_line(
        input logic [LINE_COUNT_BITS-1:0] v
    );
        logic [WideW-1:0] w;
        w = WideW'(v);
        if (w > WideW'(FIELD_MAX)) begin
            clamp_line = FIELD_MAX;
        end else begin
            clamp_line = w[OUT_LINE_W-1:0];
        end
    endfunction

    assign is_nl    = (i_text_byte == CH_NEWLINE);
    assign is_slash = (i_text_byte == CH_SLASH);
    assign is_star  = (i_text_byte == CH_STAR);

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && emit;

    always_comb begin
        n_mode   = r_mode;
        n_line   = r_line;
        n_open   = r_open;
        emit     = 1'b1;
        o_cmd    = '0;
        o_cmd.first_byte  = i_text_byte;
        o_cmd.second_byte = i_text_byte;

        case (r_mode)
            MODE_SLASH: begin
                o_cmd.two = 1'b1;
                if (is_slash) begin
                    o_cmd.first_byte  = CH_SPACE;
                    o_cmd.second_byte = CH_SPACE;
                    n_mode = MODE_LINE;
                end else if (is_star) begin
                    o_cmd.first_byte  = CH_SPACE;
                    o_cmd.second_byte = CH_SPACE;
                    n_open = r_line;
                    n_mode = MODE_BLOCK;
                end else begin
                    // release the held slash, then the byte as plain text
                    o_cmd.first_byte = CH_SLASH;
                    n_mode = MODE_NORMAL;
                end
            end
            MODE_LINE: begin
                if (is_nl) begin
                    n_mode = MODE_NORMAL;
                end else begin
                    o_cmd.first_byte = CH_SPACE;
                end
            end
            MODE_BLOCK, MODE_BLOCK_STAR: begin
                if (is_nl) begin
                    n_mode = MODE_BLOCK;
                end else begin
                    o_cmd.first_byte = CH_SPACE;
                    if (is_star) begin
                        n_mode = MODE_BLOCK_STAR;
                    end else if (is_slash && (r_mode == MODE_BLOCK_STAR)) begin
                        n_mode = MODE_NORMAL;
                    end else begin
                        n_mode = MODE_BLOCK;
                    end
                end
            end
            default: begin
                // normal text: hold a slash unless it ends the text
                if (is_slash && !i_is_final) begin
                    emit   = 1'b0;
                    n_mode = MODE_SLASH;
                end
            end
        endcase

        if (is_nl && !(&r_line)) begin
            n_line = r_line + 1'b1;
        end

        in_block = (n_mode == MODE_BLOCK) || (n_mode == MODE_BLOCK_STAR);

        if (i_is_final) begin
            o_cmd.fin         = 1'b1;
            o_cmd.err         = in_block;
            o_cmd.open_line   = in_block ? clamp_line(n_open) : '0;
            o_cmd.total_lines = clamp_line(n_line);
            n_mode = MODE_NORMAL;
            n_line = LINE_COUNT_BITS'(1);
            n_open = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_line <= LINE_COUNT_BITS'(1);
            r_open <= '0;
        end else if (accept) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_open <= n_open;
        end
    end

endmodule

[rtl/core/cbf_queue.sv]
`timescale 1ns / 1ps
// Short entry queue between the front end and the output stage.
module cbf_queue #(
    parameter int DEPTH = cbf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cbf_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output cbf_pkg::t_cmd      o_cmd,
    output cbf_pkg::t_q_status o_status
);
    import cbf_pkg::*;

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;

    assign o_cmd          = r_mem[r_rd];
    assign o_status.full  = (r_cnt == CntW'(DEPTH));
    assign o_status.empty = (r_cnt == '0);

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

[rtl/core/cbf_back.sv]
`timescale 1ns / 1ps
// Back end: unpacks entries to one registered word per cycle unless stalled or queue empty.
module cbf_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  cbf_pkg::t_cmd                         i_cmd,
    input  cbf_pkg::t_q_status                    i_q_status,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [7:0]                            o_out_byte,
    output logic                                  o_out_final,
    output logic                                  o_unclosed_error,
    output logic [cbf_pkg::OUT_LINE_W-1:0]        o_open_line,
    output logic [cbf_pkg::OUT_LINE_W-1:0]        o_total_lines
);
    import cbf_pkg::*;

    logic                  r_valid;
    logic                  r_second;
    logic [7:0]            r_byte;
    logic                  r_fin;
    logic                  r_err;
    logic [OUT_LINE_W-1:0] r_open_line;
    logic [OUT_LINE_W-1:0] r_total;
    logic                  load;
    logic                  take;
    logic                  last_word;

    assign load      = !r_valid || i_ready;
    assign take      = load && !i_q_status.empty;
    assign last_word = !i_cmd.two || r_second;
    assign o_pop     = take && last_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_status.empty;
            if (take) begin
                r_second <= !last_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte      <= r_second ? i_cmd.second_byte : i_cmd.first_byte;
            r_fin       <= last_word & i_cmd.fin;
            r_err       <= last_word & i_cmd.err;
            r_open_line <= last_word ? i_cmd.open_line : '0;
            r_total     <= last_word ? i_cmd.total_lines : '0;
        end
    end

    assign o_valid          = r_valid;
    assign o_out_byte       = r_byte;
    assign o_out_final      = r_fin;
    assign o_unclosed_error = r_err;
    assign o_open_line      = r_open_line;
    assign o_total_lines    = r_total;

endmodule

[rtl/core/comment_blanking_filter_top.sv]
`timescale 1ns / 1ps
// Top level of the comment blanking filter: front end, entry queue, output stage.
// Path: the first word of a byte passes through the entry queue and then the output
//   register; a held slash produces nothing until the following byte arrives.
// Throughput: one byte per cycle while the entry queue is not full; a byte that yields two
//   words holds the output for both, and the entry queue (QUEUE_DEPTH entries) lets input keep flowing meanwhile.
// Reset: synchronous, active low; clears scan mode to normal text, line count to one,
//   open-comment line to zero, and empties the queue and output register.
module comment_blanking_filter_top #(
    parameter int LINE_COUNT_BITS = cbf_pkg::LINE_COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH     = cbf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input word channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_is_final,
    // output word channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_final,
    output logic        o_unclosed_error,
    output logic [19:0] o_open_line,
    output logic [19:0] o_total_lines
);
    import cbf_pkg::*;

    // Front end to queue
    logic      push;
    t_cmd      push_cmd;
    // Queue to back end
    logic      pop;
    t_cmd      head_cmd;
    t_q_status q_status;

    // Classify each word, track mode and line counts, and build an entry holding the
    // one or two output words it causes. The end-of-text report rides on the entry too.
    cbf_front #(
        .LINE_COUNT_BITS (LINE_COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_text_byte (i_text_byte),
        .i_is_final  (i_is_final),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    // Decouple the two sides so a stalled consumer does not stall the scanner at once.
    cbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    // Drain entries one word per cycle while the output is taken; advance past an entry after its last word.
    cbf_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (head_cmd),
        .i_q_status       (q_status),
        .o_pop            (pop),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_out_final      (o_out_final),
        .o_unclosed_error (o_unclosed_error),
        .o_open_line      (o_open_line),
        .o_total_lines    (o_total_lines)
    );

endmodule

[rtl/core/cbf_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the comment blanking filter, bound to the top level.
module cbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_text_byte,
    input logic        i_is_final,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [7:0]  o_out_byte,
    input logic        o_out_final,
    input logic        o_unclosed_error,
    input logic [19:0] o_open_line,
    input logic [19:0] o_total_lines
);

    // An error is reported only on the last word of a text.
    a_err_on_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unclosed_error) |-> o_out_final)
        else $error("unclosed error on a non-final word");

    // The open comment starts on a real line no later than the last line.
    a_open_line_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_unclosed_error) |->
            (o_open_line != 20'd0) && (o_open_line <= o_total_lines))
        else $error("open comment line out of range");

    // Line fields are zero except on the final word, where the total is at least one.
    a_line_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_final ? (o_total_lines != 20'd0)
                         : ((o_total_lines == 20'd0) && (o_open_line == 20'd0))))
        else $error("line fields wrong for final flag");

    // A word offered and not taken is still offered next cycle.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_byte)))
        else $error("output word dropped while stalled");

    // An input word offered and not taken stays offered, unchanged, next cycle.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=>
            (i_in_valid && $stable(i_text_byte) && $stable(i_is_final)))
        else $error("input word changed while stalled");

endmodule

bind comment_blanking_filter_top cbf_checker u_cbf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .i_text_byte      (i_text_byte),
    .i_is_final       (i_is_final),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_out_byte       (o_out_byte),
    .o_out_final      (o_out_final),
    .o_unclosed_error (o_unclosed_error),
    .o_open_line      (o_open_line),
    .o_total_lines    (o_total_lines)
);
